// File: src/acpl_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants, register indexes and state encoding of the ambient cancel loop.
package acpl_pkg;

    localparam int HISTORY_DEPTH_DEF = 10;
    localparam int DECIMATION_DEF    = 5;

    localparam int WORD_W     = 24;
    localparam int SAMPLE_W   = 22;
    localparam int GAIN8_W    = 8;
    localparam int FB_W       = 16;
    localparam int LEVEL_W    = 4;
    localparam int GAIN_W     = LEVEL_W + FB_W;
    localparam int ESUM_W     = 32;
    localparam int PPROD_W    = SAMPLE_W + 1 + GAIN8_W + 1;
    localparam int IPROD_W    = ESUM_W + GAIN8_W + 1;
    localparam int PI_W       = IPROD_W + 1;

    localparam int S_TDATA_W  = 4 * WORD_W;
    localparam int M_TDATA_W  = 72;
    localparam int M_TUSER_W  = 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SAMPLE_W;

    localparam int PI_SCALE   = 1000;
    localparam int LEVEL_MAX  = 10;
    localparam int PI_LIMIT   = (LEVEL_MAX + 1) * PI_SCALE;
    localparam int REM_W      = 14;

    localparam logic signed [SAMPLE_W-1:0] TARGET_RST = SAMPLE_W'(1000);
    localparam logic [GAIN8_W-1:0]         PROP_RST   = GAIN8_W'(10);
    localparam logic [GAIN8_W-1:0]         INTEG_RST  = GAIN8_W'(1);
    localparam logic [FB_W-1:0]            FB_RST     = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET   = 2'd0,
        CFG_PROP     = 2'd1,
        CFG_INTEG    = 2'd2,
        CFG_FEEDBACK = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_PREP,
        ST_DIV,
        ST_ERR,
        ST_INTEG,
        ST_MUL,
        ST_ADD,
        ST_LEVEL,
        ST_DONE
    } state_t;

endpackage

// File: src/acpl_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
module acpl_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 10,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/ambient_cancel_pi_loop_core.sv
`timescale 1ns / 1ps
// Top level of the ambient cancellation PI loop: history memory, averaging and PI sequencer.
// An ordinary sample's word is registered and appears in the cycle after it is accepted.
// On the last phase the word follows a sweep of the history RAM, a reciprocal multiply for
// the divide by HISTORY_DEPTH and repeated subtraction of 1000 for a level of up to ten.
// Throughput: one sample per cycle between updates, one at a time, while the output is not
// stalled; the sequencer is busy for the whole update. Reset clears the phase, integral and
// output valid and sets the configuration registers to their defaults.
module ambient_cancel_pi_loop_core #(
    parameter int HISTORY_DEPTH = acpl_pkg::HISTORY_DEPTH_DEF,
    parameter int DECIMATION    = acpl_pkg::DECIMATION_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // led1_word [23:0], led2_word [47:24], amb1_word [71:48], amb2_word [95:72]
    input  logic [acpl_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // ir_sample [21:0], red_sample [43:22], cancel_level [47:44], gain_word [67:48], zeros
    output logic [acpl_pkg::M_TDATA_W-1:0]   m_tdata,
    // gain_update [0]
    output logic [acpl_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [acpl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [acpl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import acpl_pkg::*;

    localparam int AW      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int DCW     = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam int TOT_W   = SAMPLE_W + $clog2(HISTORY_DEPTH);
    localparam int DIV_SH  = TOT_W + $clog2(HISTORY_DEPTH);
    localparam int RCP_W   = TOT_W + 1;
    localparam int DPROD_W = TOT_W + RCP_W;

    localparam logic [AW-1:0]     SLOT_LAST = AW'(HISTORY_DEPTH - 1);
    localparam logic [DCW-1:0]    DEC_LAST  = DCW'(DECIMATION - 1);
    localparam logic [CNT_W-1:0]  CNT_END   = CNT_W'(HISTORY_DEPTH);
    // Rounded-up reciprocal of the depth; exact for every magnitude below 2**TOT_W.
    localparam logic [RCP_W-1:0]  RCP_C     =
        RCP_W'(((longint'(1) << DIV_SH) + longint'(HISTORY_DEPTH) - 1) /
               longint'(HISTORY_DEPTH));
    localparam logic [REM_W-1:0]  SCALE_C   = REM_W'(PI_SCALE);
    localparam logic signed [PI_W-1:0] LIMIT_C = PI_W'(PI_LIMIT);

    state_t state_reg, state_next;

    // configuration registers
    logic signed [SAMPLE_W-1:0] target_reg;
    logic [GAIN8_W-1:0]         prop_reg;
    logic [GAIN8_W-1:0]         igain_reg;
    logic [FB_W-1:0]            fb_reg;

    // phase tracking as slot and decimation counters
    logic [AW-1:0]  slot_reg, slot_next;
    logic [DCW-1:0] dec_reg, dec_next;

    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       pend_reg, pend_next;
    logic signed [TOT_W-1:0]    total_reg, total_next;
    logic                       neg_reg, neg_next;
    logic [TOT_W-1:0]           dq_reg, dq_next;
    logic signed [SAMPLE_W:0]   err_reg, err_next;
    logic signed [ESUM_W-1:0]   esum_reg, esum_next;
    logic signed [PPROD_W-1:0]  pprod_reg, pprod_next;
    logic signed [IPROD_W-1:0]  iprod_reg, iprod_next;
    logic signed [PI_W-1:0]     pi_reg, pi_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [LEVEL_W-1:0]         lvl_reg, lvl_next;
    logic [SAMPLE_W-1:0]        irh_reg, irh_next;
    logic [SAMPLE_W-1:0]        redh_reg, redh_next;

    logic                       ovalid_reg, ovalid_next;
    logic [SAMPLE_W-1:0]        oir_reg, oir_next;
    logic [SAMPLE_W-1:0]        ored_reg, ored_next;
    logic                       oupd_reg, oupd_next;
    logic [LEVEL_W-1:0]         olvl_reg, olvl_next;
    logic [GAIN_W-1:0]          oword_reg, oword_next;

    logic in_fire, out_free, is_last, is_store;
    logic ram_we, ram_re;
    logic [SAMPLE_W-1:0] ram_rdata;

    // ambient mean, truncated toward zero
    logic signed [SAMPLE_W:0] amb_sum, amb_adj;
    logic [SAMPLE_W-1:0]      amb_mean;

    // datapath helpers
    logic [DPROD_W-1:0]        div_prod;
    logic [SAMPLE_W-1:0]       avg_mag;
    logic signed [SAMPLE_W-1:0] avg_s;
    logic signed [ESUM_W:0]    isum;
    logic signed [GAIN8_W:0]   prop_s, igain_s;

    assign out_free = !ovalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign is_last  = (slot_reg == SLOT_LAST) && (dec_reg == '0);
    assign is_store = (dec_reg == '0);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        amb_sum  = $signed({s_tdata[48+SAMPLE_W-1], s_tdata[48 +: SAMPLE_W]})
                 + $signed({s_tdata[72+SAMPLE_W-1], s_tdata[72 +: SAMPLE_W]});
        amb_adj  = amb_sum + $signed({{SAMPLE_W{1'b0}}, amb_sum[SAMPLE_W]});
        amb_mean = amb_adj[SAMPLE_W:1];
    end

    acpl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (amb_mean),
        .re    (ram_re),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Handshake and memory strobes. The write of the last slot lands at the accept
    // edge, before the sweep issues its first read, so no forwarding is needed.
    always_comb
    begin
        s_tready = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = out_free;
                ram_we   = in_fire && is_store;
            end
            ST_SUM:
            begin
                ram_re = (cnt_reg != CNT_END);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && is_last)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if ((cnt_reg == CNT_END) && pend_reg)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:  state_next = ST_DIV;
            ST_DIV:   state_next = ST_ERR;
            ST_ERR:   state_next = ST_INTEG;
            ST_INTEG: state_next = ST_MUL;
            ST_MUL:   state_next = ST_ADD;
            ST_ADD:   state_next = ST_LEVEL;
            ST_LEVEL:
            begin
                if (pi_reg[PI_W-1] || (pi_reg >= LIMIT_C) || (rem_reg < SCALE_C))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        slot_next   = slot_reg;
        dec_next    = dec_reg;
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        total_next  = total_reg;
        neg_next    = neg_reg;
        dq_next     = dq_reg;
        err_next    = err_reg;
        esum_next   = esum_reg;
        pprod_next  = pprod_reg;
        iprod_next  = iprod_reg;
        pi_next     = pi_reg;
        rem_next    = rem_reg;
        lvl_next    = lvl_reg;
        irh_next    = irh_reg;
        redh_next   = redh_reg;
        ovalid_next = ovalid_reg && !m_tready;
        oir_next    = oir_reg;
        ored_next   = ored_reg;
        oupd_next   = oupd_reg;
        olvl_next   = olvl_reg;
        oword_next  = oword_reg;

        div_prod  = dq_reg * RCP_C;
        avg_mag   = dq_reg[SAMPLE_W-1:0];
        avg_s     = neg_reg ? -$signed(avg_mag) : $signed(avg_mag);
        isum      = {esum_reg[ESUM_W-1], esum_reg}
                  + {{(ESUM_W - SAMPLE_W){err_reg[SAMPLE_W]}}, err_reg};
        prop_s    = $signed({1'b0, prop_reg});
        igain_s   = $signed({1'b0, igain_reg});

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (is_last)
                    begin
                        slot_next  = '0;
                        dec_next   = '0;
                        cnt_next   = '0;
                        pend_next  = 1'b0;
                        total_next = '0;
                        irh_next   = s_tdata[0 +: SAMPLE_W];
                        redh_next  = s_tdata[24 +: SAMPLE_W];
                    end
                    else
                    begin
                        if (dec_reg == DEC_LAST)
                        begin
                            dec_next  = '0;
                            slot_next = slot_reg + 1'b1;
                        end
                        else
                        begin
                            dec_next = dec_reg + 1'b1;
                        end
                        ovalid_next = 1'b1;
                        oir_next    = s_tdata[0 +: SAMPLE_W];
                        ored_next   = s_tdata[24 +: SAMPLE_W];
                        oupd_next   = 1'b0;
                        olvl_next   = '0;
                        oword_next  = '0;
                    end
                end
            end
            ST_SUM:
            begin
                if (pend_reg)
                begin
                    total_next = total_reg
                               + $signed({{(TOT_W - SAMPLE_W){ram_rdata[SAMPLE_W-1]}},
                                          ram_rdata});
                end
                pend_next = (cnt_reg != CNT_END);
                if (cnt_reg != CNT_END)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PREP:
            begin
                neg_next  = total_reg[TOT_W-1];
                dq_next   = total_reg[TOT_W-1] ? TOT_W'(-total_reg) : TOT_W'(total_reg);
            end
            ST_DIV:
            begin
                // Magnitude divided by the depth through the scaled reciprocal.
                dq_next = TOT_W'(div_prod[DPROD_W-1:DIV_SH]);
            end
            ST_ERR:
            begin
                err_next = $signed({avg_s[SAMPLE_W-1], avg_s})
                         - $signed({target_reg[SAMPLE_W-1], target_reg});
            end
            ST_INTEG:
            begin
                if (isum[ESUM_W] != isum[ESUM_W-1])
                begin
                    esum_next = isum[ESUM_W] ? {1'b1, {(ESUM_W-1){1'b0}}}
                                             : {1'b0, {(ESUM_W-1){1'b1}}};
                end
                else
                begin
                    esum_next = isum[ESUM_W-1:0];
                end
            end
            ST_MUL:
            begin
                pprod_next = err_reg * prop_s;
                iprod_next = esum_reg * igain_s;
            end
            ST_ADD:
            begin
                pi_next  = {{(PI_W - PPROD_W){pprod_reg[PPROD_W-1]}}, pprod_reg}
                         + {iprod_reg[IPROD_W-1], iprod_reg};
                rem_next = pi_next[REM_W-1:0];
                lvl_next = '0;
            end
            ST_LEVEL:
            begin
                if (pi_reg[PI_W-1])
                begin
                    lvl_next = '0;
                end
                else if (pi_reg >= LIMIT_C)
                begin
                    lvl_next = LEVEL_W'(LEVEL_MAX);
                end
                else if (rem_reg >= SCALE_C)
                begin
                    rem_next = rem_reg - SCALE_C;
                    lvl_next = lvl_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    oir_next    = irh_reg;
                    ored_next   = redh_reg;
                    oupd_next   = 1'b1;
                    olvl_next   = lvl_reg;
                    oword_next  = {lvl_reg, fb_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            slot_reg   <= '0;
            dec_reg    <= '0;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            esum_reg   <= '0;
            ovalid_reg <= 1'b0;
            target_reg <= TARGET_RST;
            prop_reg   <= PROP_RST;
            igain_reg  <= INTEG_RST;
            fb_reg     <= FB_RST;
        end
        else
        begin
            state_reg  <= state_next;
            slot_reg   <= slot_next;
            dec_reg    <= dec_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
            esum_reg   <= esum_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_TARGET:   target_reg <= $signed(cfg_data[SAMPLE_W-1:0]);
                    CFG_PROP:     prop_reg   <= cfg_data[GAIN8_W-1:0];
                    CFG_INTEG:    igain_reg  <= cfg_data[GAIN8_W-1:0];
                    CFG_FEEDBACK: fb_reg     <= cfg_data[FB_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        neg_reg   <= neg_next;
        dq_reg    <= dq_next;
        err_reg   <= err_next;
        pprod_reg <= pprod_next;
        iprod_reg <= iprod_next;
        pi_reg    <= pi_next;
        rem_reg   <= rem_next;
        lvl_reg   <= lvl_next;
        irh_reg   <= irh_next;
        redh_reg  <= redh_next;
        oir_reg   <= oir_next;
        ored_reg  <= ored_next;
        oupd_reg  <= oupd_next;
        olvl_reg  <= olvl_next;
        oword_reg <= oword_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {(M_TDATA_W - 2 * SAMPLE_W - LEVEL_W - GAIN_W)'(0),
                       oword_reg, olvl_reg, ored_reg, oir_reg};
    assign m_tuser  = oupd_reg;

endmodule

// File: src/acpl_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the ambient cancel loop, bound to the top level.
module acpl_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [acpl_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [acpl_pkg::M_TUSER_W-1:0]   m_tuser
);
    import acpl_pkg::*;

    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] word_level;
    logic [GAIN_W+LEVEL_W-1:0] gain_fields;

    assign level       = m_tdata[47:44];
    assign word_level  = m_tdata[67:64];
    assign gain_fields = m_tdata[67:44];

    // A stalled result word keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Without an update the level and gain word are zero.
    a_no_update_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> gain_fields == '0)
        else $error("level or gain word set without an update");

    // An update carries a clamped level, repeated in the upper gain word bits.
    a_update_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (level <= LEVEL_W'(LEVEL_MAX)) && (word_level == level))
        else $error("update level out of range or not packed into gain word");

    // A new sample is never taken while a result is stuck in the output register.
    a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !(m_tvalid && !m_tready))
        else $error("sample accepted while output stalled");

endmodule

bind ambient_cancel_pi_loop_core acpl_checker u_acpl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

// File: verif/ambient_cancel_pi_loop_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the ambient cancellation PI loop: stream stimulus and scoreboard.
module ambient_cancel_pi_loop_core_tb;

    import acpl_pkg::*;

    localparam int     LAST_PHASE   = (HISTORY_DEPTH_DEF - 1) * DECIMATION_DEF;
    localparam longint SAMPLE_MAX   = 2097151;
    localparam longint SAMPLE_MIN   = -2097152;
    localparam longint ESUM_MAX     = 2147483647;
    localparam longint ESUM_MIN     = -(ESUM_MAX + 1);
    localparam int     RANDOM_ITEMS = 800;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     STALL_LIMIT  = 2000;
    localparam int     DRAIN_CYCLES = 100;
    localparam int     PRINT_LIMIT  = 50;

    typedef struct packed {
        logic [3:0]          pad;
        logic [GAIN_W-1:0]   gain_word;
        logic [LEVEL_W-1:0]  level;
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] ir;
    } out_word_t;

    typedef struct packed {
        logic      update;
        out_word_t word;
    } cancel_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predicted loop state and register copies.
    logic signed [SAMPLE_W-1:0] cur_target;
    logic [GAIN8_W-1:0]         cur_prop;
    logic [GAIN8_W-1:0]         cur_integ;
    logic [FB_W-1:0]            cur_fb;
    int                         run_phase;
    int                         amb_hist [HISTORY_DEPTH_DEF];
    int                         err_sum;

    cancel_result_t cancel_out_q [$];
    int             mismatch_cnt;
    int             idle_cycles;
    int             hold_cnt;
    logic           hold_req;
    logic           tx_idle_en;
    logic           rx_idle_en;

    ambient_cancel_pi_loop_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [SAMPLE_W-1:0] clamp22(input longint v);
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        if (v < SAMPLE_MIN)
            v = SAMPLE_MIN;
        return v[SAMPLE_W-1:0];
    endfunction

    // Ambient word with random don't-care bits above the sample.
    function automatic logic [WORD_W-1:0] amb_word(input longint v);
        return {2'($urandom), clamp22(v)};
    endfunction

    function automatic logic [WORD_W-1:0] rand24();
        return 24'($urandom);
    endfunction

    function automatic logic [GAIN8_W-1:0] rand_gain();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_target();
        case ($urandom_range(0, 3))
            0: return clamp22(SAMPLE_MIN);
            1: return clamp22(SAMPLE_MAX);
            default: return 22'($urandom);
        endcase
    endfunction

    task automatic step_cancel_loop(input logic [S_TDATA_W-1:0] data);
        cancel_result_t             res;
        logic signed [SAMPLE_W-1:0] amb1;
        logic signed [SAMPLE_W-1:0] amb2;
        longint                     total;
        longint                     err;
        longint                     integ;
        longint                     pi;
        longint                     q;
        int                         i;
        res = '0;
        res.word.ir  = data[0 +: SAMPLE_W];
        res.word.red = data[WORD_W +: SAMPLE_W];
        amb1 = data[2 * WORD_W +: SAMPLE_W];
        amb2 = data[3 * WORD_W +: SAMPLE_W];
        if (run_phase % DECIMATION_DEF == 0)
            amb_hist[run_phase / DECIMATION_DEF] = (int'(amb1) + int'(amb2)) / 2;
        if (run_phase == LAST_PHASE)
        begin
            total = 0;
            for (i = 0; i < HISTORY_DEPTH_DEF; i++)
                total += longint'(amb_hist[i]);
            err = total / HISTORY_DEPTH_DEF - longint'(cur_target);
            integ = longint'(err_sum) + err;
            if (integ > ESUM_MAX)
                integ = ESUM_MAX;
            if (integ < ESUM_MIN)
                integ = ESUM_MIN;
            err_sum = int'(integ);
            pi = err * longint'(cur_prop) + integ * longint'(cur_integ);
            q = pi / PI_SCALE;
            if (q < 0)
                q = 0;
            if (q > LEVEL_MAX)
                q = LEVEL_MAX;
            res.update = 1'b1;
            res.word.level = LEVEL_W'(q);
            res.word.gain_word = {res.word.level, cur_fb};
        end
        cancel_out_q.push_back(res);
        run_phase = (run_phase == LAST_PHASE) ? 0 : run_phase + 1;
    endtask

    // Entered and left at a falling edge.
    task automatic send_sample(input logic [S_TDATA_W-1:0] data);
        while (tx_idle_en && $urandom_range(0, 99) < 19)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        step_cancel_loop(data);
        @(negedge clk);
    endtask

    // Writes all four registers once the block has drained.
    task automatic set_config(input logic [SAMPLE_W-1:0] target, input logic [GAIN8_W-1:0] pg,
                              input logic [GAIN8_W-1:0] ig, input logic [FB_W-1:0] fb);
        cfg_idx_t              order [4];
        logic [CFG_DATA_W-1:0] vals  [4];
        int                    i;
        order = '{CFG_TARGET, CFG_PROP, CFG_INTEG, CFG_FEEDBACK};
        vals  = '{target, CFG_DATA_W'(pg), CFG_DATA_W'(ig), CFG_DATA_W'(fb)};
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (cancel_out_q.size() != 0);
        for (i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            @(negedge clk);
        end
        cfg_valid  <= 1'b0;
        cur_target = target;
        cur_prop   = pg;
        cur_integ  = ig;
        cur_fb     = fb;
    endtask

    // Sends samples through the last phase, steering the ambient average to target + goal.
    task automatic run_to_update(input longint goal, input int jitter, input int noise_pct,
                                 output int count);
        longint v;
        longint w;
        longint d;
        count = 0;
        v = longint'(cur_target) + goal;
        do
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_sample({$urandom, $urandom, $urandom});
            else
            begin
                w = v + longint'($urandom_range(0, 2 * jitter)) - longint'(jitter);
                d = longint'($urandom_range(0, 3000));
                send_sample({amb_word(w - d), amb_word(w + d), rand24(), rand24()});
            end
            count++;
        end
        while (run_phase != 0);
    endtask

    task automatic test_field_extremes;
        logic [WORD_W-1:0] led_tab [8];
        longint            amb_a   [5];
        longint            amb_b   [5];
        int                i;
        int                n;
        led_tab = '{24'h000000, 24'hFFFFFF, 24'h200000, 24'h1FFFFF,
                    24'hC00000, 24'h3FFFFF, 24'h555555, 24'hAAAAAA};
        // Odd negative sums check that the ambient mean truncates toward zero.
        amb_a = '{SAMPLE_MAX, SAMPLE_MIN, -3, SAMPLE_MAX, 5};
        amb_b = '{SAMPLE_MAX, SAMPLE_MIN, 0, SAMPLE_MIN, 0};
        for (i = 0; i < 24; i++)
        begin
            if (i % DECIMATION_DEF == 0)
                send_sample({amb_word(amb_b[i / DECIMATION_DEF]),
                             amb_word(amb_a[i / DECIMATION_DEF]),
                             led_tab[(i + 3) % 8], led_tab[i % 8]});
            else
                send_sample({$urandom, $urandom, $urandom});
        end
        run_to_update(0, 0, 0, n);
    endtask

    task automatic test_level_clamp;
        int k;
        int n;
        // With no integral term each level step is exactly ten units of error.
        set_config(clamp22(1000), 8'd100, 8'd0, 16'hFFFF);
        for (k = -1; k <= LEVEL_MAX + 1; k++)
            run_to_update(longint'(10 * k + int'($urandom_range(0, 9))), 0, 0, n);
        set_config(clamp22(SAMPLE_MIN), 8'd255, 8'd255, 16'h0000);
        run_to_update(5000000, 0, 0, n);
        set_config(clamp22(SAMPLE_MAX), 8'd255, 8'd255, 16'h0000);
        run_to_update(-5000000, 0, 0, n);
    endtask

    task automatic test_backpressure;
        int n;
        tx_idle_en = 1'b0;
        hold_req   = 1'b1;
        run_to_update(0, 5, 10, n);
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random;
        int     sent;
        int     n;
        longint goal;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            tx_idle_en = (sent < 200 || sent >= 500);
            rx_idle_en = tx_idle_en;
            if ($urandom_range(0, 2) == 0)
                set_config(rand_target(), rand_gain(), rand_gain(), 16'($urandom));
            // Pull the integral back toward zero so that middle levels stay reachable.
            if (err_sum > 20000 || err_sum < -20000)
                goal = -longint'(err_sum) + longint'($urandom_range(0, 4000)) - 2000;
            else if ($urandom_range(0, 4) == 0)
                goal = ($urandom_range(0, 1) != 0 ? 1 : -1) *
                       longint'($urandom_range(0, 4200000));
            else
                goal = longint'($urandom_range(0, 6000)) - 3000;
            run_to_update(goal, int'($urandom_range(0, 40)), 20, n);
            sent += n;
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Largest errors in both directions, first with only the full integral gain and then
    // with only the full proportional gain; a swing to the 32-bit limit would take hundreds of updates.
    task automatic test_integral_windup;
        int n;
        int i;
        set_config(clamp22(SAMPLE_MIN), 8'd0, 8'd255, 16'h5A5A);
        for (i = 0; i < 4; i++)
            run_to_update(5000000, 0, 0, n);
        set_config(clamp22(SAMPLE_MAX), 8'd255, 8'd0, 16'hA5A5);
        for (i = 0; i < 4; i++)
            run_to_update(-5000000, 0, 0, n);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            if (mismatch_cnt < PRINT_LIMIT)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            m_tready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= HOLD_CYCLES)
            begin
                hold_req = 1'b0;
                hold_cnt = 0;
            end
        end
        else
            m_tready <= !(rx_idle_en && $urandom_range(0, 99) < 19);
    end

    always @(posedge clk)
    begin
        cancel_result_t want;
        out_word_t      got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (cancel_out_q.size() == 0)
            begin
                if (mismatch_cnt < PRINT_LIMIT)
                    $display("%0t: unexpected output word, expected none, actual 0x%0h",
                             $time, m_tdata);
                mismatch_cnt++;
            end
            else
            begin
                want = cancel_out_q.pop_front();
                check_field("ir_sample", 32'(want.word.ir), 32'(got.ir));
                check_field("red_sample", 32'(want.word.red), 32'(got.red));
                check_field("cancel_level", 32'(want.word.level), 32'(got.level));
                check_field("gain_word", 32'(want.word.gain_word), 32'(got.gain_word));
                check_field("tdata padding", 32'(want.word.pad), 32'(got.pad));
                check_field("gain_update", 32'(want.update), 32'(m_tuser[0]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_TARGET;
        cfg_data     = '0;
        hold_req     = 1'b0;
        hold_cnt     = 0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        mismatch_cnt = 0;
        idle_cycles  = 0;
        cur_target   = TARGET_RST;
        cur_prop     = PROP_RST;
        cur_integ    = INTEG_RST;
        cur_fb       = FB_RST;
        run_phase    = 0;
        err_sum      = 0;
        amb_hist     = '{default: 0};
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_field_extremes();
        test_level_clamp();
        test_backpressure();
        test_random();
        test_integral_windup();

        s_tvalid <= 1'b0;
        while (cancel_out_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
